[design/wmc_pkg.sv]
package wmc_pkg;

	// Operating modes, as reported on mode_now.
	localparam logic [2:0] MODE_OFF    = 3'd0;
	localparam logic [2:0] MODE_RAIN   = 3'd1;
	localparam logic [2:0] MODE_TON    = 3'd2;
	localparam logic [2:0] MODE_TPAUSE = 3'd3;
	localparam logic [2:0] MODE_CONT   = 3'd4;
	localparam logic [2:0] MODE_FINISH = 3'd5;

	// Item kinds carried on s_tuser.
	localparam logic [1:0] FUNC_TICK = 2'd0;
	localparam logic [1:0] FUNC_RAIN = 2'd1;
	localparam logic [1:0] FUNC_TIMED = 2'd2;
	localparam logic [1:0] FUNC_CONT = 2'd3;

	// Lamp codes.
	localparam logic [1:0] LAMP_NONE  = 2'd0;
	localparam logic [1:0] LAMP_RAIN  = 2'd1;
	localparam logic [1:0] LAMP_TIMED = 2'd2;
	localparam logic [1:0] LAMP_CONT  = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] REG_SLOW_SWEEP = 2'd0;
	localparam logic [1:0] REG_FAST_SWEEP = 2'd1;
	localparam logic [1:0] REG_DROPS      = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [9:0] SLOW_SWEEP_RST = 10'd200;
	localparam logic [9:0] FAST_SWEEP_RST = 10'd100;
	localparam logic [7:0] DROPS_RST      = 8'd10;

	// Converter scaling constants.
	localparam logic [8:0] PAUSE_GAIN   = 9'd400;
	localparam logic [8:0] RAIN_GAIN    = 9'd500;
	localparam logic [9:0] SAMPLE_FULL  = 10'd1023;
	localparam logic [8:0] PAUSE_OFFSET = 9'd100;
	localparam logic [8:0] PAUSE_RST    = 9'd100;

	// Drop interval is this constant divided by the rain speed.
	localparam logic [6:0] DROP_DIVIDEND = 7'd100;

	localparam int TDATA_IN_W  = 24;
	localparam int TDATA_OUT_W = 16;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_in;    // capture the accepted item
		logic mul;        // register the scaled samples
		logic quo;        // register the quotients by full scale
		logic div_start;  // start the drop interval division
		logic apply;      // update the wiper state
		logic emit;       // load the output register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_tick;
		logic div_busy;
	} stat_t;

endpackage

[design/wiper_mode_controller.sv]
// Windscreen wiper mode controller.
// The input stream carries one item per 10 ms tick or button press. s_tuser
// holds the item kind (tick, rain, timed or continuous button); s_tdata holds
// the pause and rain converter samples. Every item produces exactly one
// result item on the output stream with the wiper position, mode lamp, drop
// LED and the current mode.
// A button press goes from capture straight to the state update and the
// output load. For a tick the samples are scaled, divided by full scale
// with a reciprocal-and-correct step, and the drop interval is found by a
// restoring divider that produces one quotient bit per cycle. One item is
// worked on at a time; the next item is accepted as soon as the previous
// result has been loaded into the output register, even if the receiver
// has not taken it yet. If the receiver stalls, the result waits in the
// output register and the following item is held in its final step until
// the register frees up. Reset puts the wiper off at position zero with
// all counters cleared, the pause length at 100 ticks and the configuration
// registers at their defaults (200 and 100 sweep ticks, 10 drops per wipe).
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must do so only while the block is idle, which the block does not enforce.
module wiper_mode_controller (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [9:0] pause_sample, [19:10] rain_sample, [23:20] zero
	input  logic [wmc_pkg::TDATA_IN_W-1:0]  s_tdata,
	// [1:0] func
	input  logic [1:0]                      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [2:0] wiper_position, [4:3] mode_lamp, [5] drop_led, [8:6] mode_now,
	// [15:9] zero
	output logic [wmc_pkg::TDATA_OUT_W-1:0] m_tdata,
	input  logic                            cfg_we,
	input  logic [1:0]                      cfg_index,
	input  logic [9:0]                      cfg_data
);

	// Command and status between the sequencer and the datapath.
	wmc_pkg::cmd_t  cmd;
	wmc_pkg::stat_t stat;

	// The sequencer walks each item through capture, scaling and division
	// (ticks only), state update and output load.
	wmc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The datapath holds the configuration, the wiper state, the arithmetic
	// and the output register.
	wmc_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tdata   (m_tdata)
	);

endmodule

[design/wmc_div.sv]
module wmc_div (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [8:0] divisor,
	output logic       busy,
	output logic [6:0] quotient
);

	logic [2:0] cnt_q;
	logic [8:0] rem_q;
	logic [8:0] dvs_q;
	logic [6:0] quo_q;
	logic [2:0] bit_idx;
	logic [9:0] trial;
	logic       fits;

	function automatic logic DROP_BIT(input logic [2:0] idx);
		logic [6:0] v;
		v = wmc_pkg::DROP_DIVIDEND;
		return v[idx];
	endfunction

	// Restoring division of a fixed dividend, one quotient bit per cycle.
	assign bit_idx = cnt_q - 3'd1;
	assign trial   = {rem_q, DROP_BIT(bit_idx)};
	assign fits    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (start) begin
			cnt_q <= 3'd7;
		end else if (cnt_q != 3'd0) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= 9'd0;
			dvs_q <= divisor;
			quo_q <= 7'd0;
		end else if (cnt_q != 3'd0) begin
			if (fits) begin
				rem_q <= 9'(trial - {1'b0, dvs_q});
			end else begin
				rem_q <= trial[8:0];
			end
			quo_q <= {quo_q[5:0], fits};
		end
	end

	assign busy     = cnt_q != 3'd0;
	assign quotient = quo_q;

endmodule

[design/wmc_datapath.sv]
module wmc_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  wmc_pkg::cmd_t                      cmd,
	output wmc_pkg::stat_t                     stat,
	input  logic [wmc_pkg::TDATA_IN_W-1:0]     s_tdata,
	input  logic [1:0]                         s_tuser,
	input  logic                               cfg_we,
	input  logic [1:0]                         cfg_index,
	input  logic [9:0]                         cfg_data,
	output logic [wmc_pkg::TDATA_OUT_W-1:0]    m_tdata
);

	// Configuration.
	logic [9:0] slow_sweep_q, fast_sweep_q;
	logic [7:0] drops_per_wipe_q;

	// Captured item and arithmetic pipeline.
	logic [1:0]  func_q;
	logic [9:0]  psamp_q, rsamp_q;
	logic [18:0] pprod_q, rprod_q;
	logic [8:0]  pquo_q, rquo_q;
	logic [10:0] prem, rrem;

	// Wiper state.
	logic [2:0] mode_q, position_q;
	logic [6:0] step_len_q, step_cnt_q;
	logic [8:0] pause_len_q, pause_cnt_q, rain_speed_q;
	logic [6:0] drop_int_q, drop_ticks_q;
	logic [7:0] drops_seen_q;
	logic [1:0] lamp_q;
	logic       led_q;

	// Next state.
	logic [2:0] mode_d, position_d;
	logic [6:0] step_len_d, step_cnt_d;
	logic [8:0] pause_len_d, pause_cnt_d, rain_speed_d;
	logic [6:0] drop_int_d, drop_ticks_d;
	logic [7:0] drops_seen_d;
	logic [1:0] lamp_d;
	logic       led_d;
	logic       wipe;

	logic       div_busy;
	logic [6:0] div_quo;

	wmc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.divisor  (rquo_q),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	assign stat.is_tick  = func_q == wmc_pkg::FUNC_TICK;
	assign stat.div_busy = div_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slow_sweep_q     <= wmc_pkg::SLOW_SWEEP_RST;
			fast_sweep_q     <= wmc_pkg::FAST_SWEEP_RST;
			drops_per_wipe_q <= wmc_pkg::DROPS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wmc_pkg::REG_SLOW_SWEEP: slow_sweep_q <= cfg_data;
				wmc_pkg::REG_FAST_SWEEP: fast_sweep_q <= cfg_data;
				wmc_pkg::REG_DROPS:      drops_per_wipe_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// x / 1023 for x below 2^19: with q0 = x >> 10 the remainder is
	// (x mod 1024) + q0, which stays below twice 1023.
	assign prem = {1'b0, pprod_q[9:0]} + {2'b0, pprod_q[18:10]};
	assign rrem = {1'b0, rprod_q[9:0]} + {2'b0, rprod_q[18:10]};

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			func_q  <= s_tuser;
			psamp_q <= s_tdata[9:0];
			rsamp_q <= s_tdata[19:10];
		end
		if (cmd.mul) begin
			pprod_q <= 19'(psamp_q * wmc_pkg::PAUSE_GAIN);
			rprod_q <= 19'(rsamp_q * wmc_pkg::RAIN_GAIN);
		end
		if (cmd.quo) begin
			pquo_q <= pprod_q[18:10] + 9'(prem >= {1'b0, wmc_pkg::SAMPLE_FULL});
			rquo_q <= rprod_q[18:10] + 9'(rrem >= {1'b0, wmc_pkg::SAMPLE_FULL});
		end
		if (cmd.emit) begin
			m_tdata <= {7'd0, mode_q, led_q, lamp_q,
				(mode_q == wmc_pkg::MODE_OFF) ? 3'd0 : position_q};
		end
	end

	always_comb begin
		mode_d       = mode_q;
		position_d   = position_q;
		step_len_d   = step_len_q;
		step_cnt_d   = step_cnt_q;
		pause_len_d  = pause_len_q;
		pause_cnt_d  = pause_cnt_q;
		rain_speed_d = rain_speed_q;
		drop_int_d   = drop_int_q;
		drop_ticks_d = drop_ticks_q;
		drops_seen_d = drops_seen_q;
		led_d        = led_q;
		wipe         = 1'b0;

		unique case (func_q)
			wmc_pkg::FUNC_TICK: begin
				if (mode_q != wmc_pkg::MODE_OFF) begin
					if (mode_q == wmc_pkg::MODE_TON || mode_q == wmc_pkg::MODE_TPAUSE) begin
						pause_len_d = pquo_q + wmc_pkg::PAUSE_OFFSET;
					end
					if (mode_q == wmc_pkg::MODE_RAIN) begin
						rain_speed_d = rquo_q;
						if (rquo_q != 9'd0) begin
							drop_int_d = div_quo;
						end
					end

					// Simulated drops.
					if (mode_q == wmc_pkg::MODE_RAIN && rain_speed_d != 9'd0) begin
						drop_ticks_d = drop_ticks_q + 7'd1;
						if (drop_ticks_d >= drop_int_d) begin
							drop_ticks_d = 7'd0;
							led_d        = ~led_q;
							if (drops_seen_q != 8'hff) begin
								drops_seen_d = drops_seen_q + 8'd1;
							end
						end
					end

					// Sweep.
					wipe = mode_q == wmc_pkg::MODE_CONT || mode_q == wmc_pkg::MODE_TON ||
						mode_q == wmc_pkg::MODE_FINISH ||
						(mode_q == wmc_pkg::MODE_RAIN && drops_seen_d >= drops_per_wipe_q);
					if (wipe) begin
						step_cnt_d = step_cnt_q + 7'd1;
						if (step_cnt_d >= step_len_q) begin
							step_cnt_d = 7'd0;
							position_d = position_q + 3'd1;
							if (position_d == 3'd0) begin
								if (mode_q == wmc_pkg::MODE_RAIN) begin
									drops_seen_d = 8'd0;
								end else if (mode_q == wmc_pkg::MODE_FINISH) begin
									mode_d = wmc_pkg::MODE_OFF;
								end else if (mode_q == wmc_pkg::MODE_TON) begin
									mode_d = wmc_pkg::MODE_TPAUSE;
								end
							end
						end
					end

					// Pause timer, also for a pause that starts on this tick.
					if (mode_d == wmc_pkg::MODE_TPAUSE) begin
						pause_cnt_d = pause_cnt_q + 9'd1;
						if (pause_cnt_d >= pause_len_d) begin
							pause_cnt_d = 9'd0;
							mode_d      = wmc_pkg::MODE_TON;
						end
					end
				end
			end
			wmc_pkg::FUNC_RAIN: begin
				if (mode_q != wmc_pkg::MODE_RAIN) begin
					step_len_d = slow_sweep_q[9:3];
					mode_d     = wmc_pkg::MODE_RAIN;
				end else begin
					mode_d = wmc_pkg::MODE_FINISH;
				end
			end
			wmc_pkg::FUNC_TIMED: begin
				if (mode_q != wmc_pkg::MODE_TON && mode_q != wmc_pkg::MODE_TPAUSE) begin
					step_len_d = slow_sweep_q[9:3];
					mode_d     = wmc_pkg::MODE_TON;
				end else begin
					mode_d = wmc_pkg::MODE_FINISH;
				end
			end
			default: begin
				if (mode_q != wmc_pkg::MODE_CONT) begin
					step_len_d = fast_sweep_q[9:3];
					mode_d     = wmc_pkg::MODE_CONT;
				end else begin
					mode_d = wmc_pkg::MODE_FINISH;
				end
			end
		endcase

		// The lamp follows the mode but holds while finishing.
		unique case (mode_d)
			wmc_pkg::MODE_OFF:    lamp_d = wmc_pkg::LAMP_NONE;
			wmc_pkg::MODE_RAIN:   lamp_d = wmc_pkg::LAMP_RAIN;
			wmc_pkg::MODE_TON,
			wmc_pkg::MODE_TPAUSE: lamp_d = wmc_pkg::LAMP_TIMED;
			wmc_pkg::MODE_CONT:   lamp_d = wmc_pkg::LAMP_CONT;
			default:              lamp_d = lamp_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= wmc_pkg::MODE_OFF;
			position_q   <= 3'd0;
			step_len_q   <= 7'd0;
			step_cnt_q   <= 7'd0;
			pause_len_q  <= wmc_pkg::PAUSE_RST;
			pause_cnt_q  <= 9'd0;
			rain_speed_q <= 9'd0;
			drop_int_q   <= 7'd0;
			drop_ticks_q <= 7'd0;
			drops_seen_q <= 8'd0;
			lamp_q       <= wmc_pkg::LAMP_NONE;
			led_q        <= 1'b0;
		end else if (cmd.apply) begin
			mode_q       <= mode_d;
			position_q   <= position_d;
			step_len_q   <= step_len_d;
			step_cnt_q   <= step_cnt_d;
			pause_len_q  <= pause_len_d;
			pause_cnt_q  <= pause_cnt_d;
			rain_speed_q <= rain_speed_d;
			drop_int_q   <= drop_int_d;
			drop_ticks_q <= drop_ticks_d;
			drops_seen_q <= drops_seen_d;
			lamp_q       <= lamp_d;
			led_q        <= led_d;
		end
	end

endmodule

[design/wmc_ctrl.sv]
module wmc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  logic           m_tready,
	input  wmc_pkg::stat_t stat,
	output wmc_pkg::cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL   = 3'd1;
	localparam logic [2:0] ST_QUO   = 3'd2;
	localparam logic [2:0] ST_DIVS  = 3'd3;
	localparam logic [2:0] ST_DIVW  = 3'd4;
	localparam logic [2:0] ST_APPLY = 3'd5;
	localparam logic [2:0] ST_EMIT  = 3'd6;

	logic [2:0] state_q, state_d;
	logic       m_tvalid_q;
	logic       slot_free;

	assign slot_free = !m_tvalid_q || m_tready;
	assign s_tready  = state_q == ST_IDLE;
	assign m_tvalid  = m_tvalid_q;

	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_MUL;
				end
			end
			ST_MUL: begin
				if (stat.is_tick) begin
					cmd.mul = 1'b1;
					state_d = ST_QUO;
				end else begin
					state_d = ST_APPLY;
				end
			end
			ST_QUO: begin
				cmd.quo = 1'b1;
				state_d = ST_DIVS;
			end
			ST_DIVS: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIVW;
			end
			ST_DIVW: begin
				if (!stat.div_busy) begin
					state_d = ST_APPLY;
				end
			end
			ST_APPLY: begin
				cmd.apply = 1'b1;
				state_d   = ST_EMIT;
			end
			ST_EMIT: begin
				if (slot_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule
